/* design/ppm_pkg.sv */
// ---------------------------------------------------------------------------
// ppm_pkg: shared types and constants for the P6 stream parser
// Header phase codes, queue entry layout, result layout and byte constants.
// ---------------------------------------------------------------------------
package ppm_pkg;

    // Header parser phase, one-hot
    typedef enum logic [5:0] {
        PH_MAGIC  = 6'b000001,
        PH_WIDTH  = 6'b000010,
        PH_HEIGHT = 6'b000100,
        PH_MAXVAL = 6'b001000,
        PH_PIXELS = 6'b010000,
        PH_IDLE   = 6'b100000
    } phase_t;

    // What a queue entry carries from the front to the back
    typedef enum logic [1:0] {
        ENT_PIXEL_BYTE = 2'd0,
        ENT_HEADER     = 2'd1,
        ENT_ERROR      = 2'd2
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        logic [7:0]  data;
        logic [1:0]  code;
    } entry_t;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_MAGIC      = 2'd0;
    localparam logic [1:0] ERR_NOT_NUMBER = 2'd1;
    localparam logic [1:0] ERR_TOO_LARGE  = 2'd2;

    // Byte constants
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Reported dimension width and stream data width
    localparam int OUT_DIM_W = 16;
    localparam int TDATA_W   = 64;
    localparam logic [2:0] TOK_POS_MAX = 3'd7;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic [OUT_DIM_W-1:0] image_width;
        logic [OUT_DIM_W-1:0] image_height;
        logic                 last_pixel;
        logic [1:0]           error_code;
    } result_t;

    // Header token separator
    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

/* design/ppm_p6_stream_parser.sv */
// ---------------------------------------------------------------------------
// ppm_p6_stream_parser: binary P6 image stream parser
// Parses the P6 header from a byte stream and emits a header word, one
// word per RGB pixel, or a single error word.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake        Payload
//  s_*      in   tvalid/tready    tdata = data_byte, tuser = start_of_file
//  m_*      out  tvalid/tready    tdata = pixel/dims/error, tuser = kind,
//                                 tlast = last_pixel
//
//  Throughput is one byte word per cycle while the queue is not full. A byte
//  word enters the queue when accepted, and the back pops it and registers
//  its result once the result register is free or draining.
//  Reset clears all parser and pixel-count state; no clearing pass.
//  A stalled output fills the two-entry queue, after which s_tready drops.
// ---------------------------------------------------------------------------
module ppm_p6_stream_parser import ppm_pkg::*; #(
    parameter int DIM_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,  // [7:0] data_byte
    input  logic [0:0]         s_tuser,  // [0] start_of_file
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [39:24] image_width,
    // [55:40] image_height, [57:56] error_code, [63:58] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,  // [1:0] kind
    output logic               m_tlast
);

    localparam int Q_DEPTH = 2;
    localparam int ENT_W   = $bits(entry_t);
    localparam int Q_W     = ENT_W + 2 * DIM_BITS;
    localparam int PAD_W   = TDATA_W - 58;

    logic                accept;
    logic                push;
    entry_t              push_entry;
    logic [DIM_BITS-1:0] push_width;
    logic [DIM_BITS-1:0] push_height;
    logic                q_not_full;
    logic                q_not_empty;
    logic                q_pop;
    logic [Q_W-1:0]      q_data;
    entry_t              pop_entry;
    logic [DIM_BITS-1:0] pop_width;
    logic [DIM_BITS-1:0] pop_height;
    result_t             result;

    assign s_tready = q_not_full;
    assign accept   = s_tvalid && s_tready;

    ppm_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (s_tdata),
        .start_of_file (s_tuser[0]),
        .push          (push),
        .entry         (push_entry),
        .ent_width     (push_width),
        .ent_height    (push_height)
    );

    ppm_queue #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_height, push_width, push_entry}),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    // Unpack the queue word
    assign pop_entry  = entry_t'(q_data[ENT_W-1:0]);
    assign pop_width  = q_data[ENT_W +: DIM_BITS];
    assign pop_height = q_data[ENT_W + DIM_BITS +: DIM_BITS];

    ppm_back #(
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_pop      (q_pop),
        .entry      (pop_entry),
        .ent_width  (pop_width),
        .ent_height (pop_height),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .result     (result)
    );

    // Pack the result word
    assign m_tdata = {{PAD_W{1'b0}}, result.error_code, result.image_height,
                      result.image_width, result.blue, result.green, result.red};
    assign m_tuser = result.kind;
    assign m_tlast = result.last_pixel;

    // A header flagged as last belongs to an empty image
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_HEADER) && m_tlast) |->
            ((m_tdata[39:24] == '0) || (m_tdata[55:40] == '0) || (DIM_BITS > OUT_DIM_W)))
        else $error("last header with nonzero dimensions");

    // An error word never marks the last pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_ERROR)) |-> !m_tlast)
        else $error("error word marked last");

    // A pixel word carries no dimensions or error code
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_PIXEL)) |-> (m_tdata[57:24] == '0))
        else $error("pixel word carries header fields");

endmodule

/* design/ppm_queue.sv */
// ---------------------------------------------------------------------------
// ppm_queue: short register FIFO between the parser front and back
// Takes one word per cycle while not full, shows the oldest word.
// ---------------------------------------------------------------------------
module ppm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign not_full  = (count_reg != CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/ppm_front.sv */
// ---------------------------------------------------------------------------
// ppm_front: header tokenizer and classifier
// Parses magic, width, height and maxval; forwards pixel bytes, the header
// and errors into the queue.
// ---------------------------------------------------------------------------
module ppm_front import ppm_pkg::*; #(
    parameter int DIM_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                start_of_file,
    output logic                push,
    output entry_t              entry,
    output logic [DIM_BITS-1:0] ent_width,
    output logic [DIM_BITS-1:0] ent_height
);

    localparam int ACC_W = DIM_BITS + 1;
    localparam int MUL_W = DIM_BITS + 5;
    localparam logic [ACC_W-1:0] ACC_SAT = ACC_W'(1) << DIM_BITS;

    phase_t              phase_reg, phase_next;
    logic                in_comment_reg, in_comment_next;
    logic                in_token_reg, in_token_next;
    logic [2:0]          tok_pos_reg, tok_pos_next;
    logic                stopped_reg, stopped_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;

    phase_t              ph;
    logic                com;
    logic                tok;
    logic                header_ph;
    logic                blank;
    logic                hash;
    logic                digit;
    logic                tok_start;
    logic                tok_cont;
    logic                tok_end;
    logic [2:0]          base_pos;
    logic                base_stop;
    logic [ACC_W-1:0]    base_acc;
    logic [MUL_W-1:0]    acc_sum;
    logic [ACC_W-1:0]    acc_upd;
    logic [7:0]          digit_val;
    logic                push_c;

    // State as seen by this byte: a start-of-file word restarts the parser
    assign ph  = start_of_file ? PH_MAGIC : phase_reg;
    assign com = start_of_file ? 1'b0 : in_comment_reg;
    assign tok = start_of_file ? 1'b0 : in_token_reg;

    assign header_ph = (ph == PH_MAGIC) || (ph == PH_WIDTH) ||
                       (ph == PH_HEIGHT) || (ph == PH_MAXVAL);
    assign blank     = is_blank(data_byte);
    assign hash      = (data_byte == CH_HASH);
    assign digit     = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign tok_start = header_ph && !com && !tok && !blank && !hash;
    assign tok_cont  = header_ph && !com && tok && !blank;
    assign tok_end   = header_ph && !com && tok && blank;

    // A fresh token starts from cleared token state
    assign base_pos  = (tok_start || start_of_file) ? 3'd0 : tok_pos_reg;
    assign base_stop = (tok_start || start_of_file) ? 1'b0 : stopped_reg;
    assign base_acc  = (tok_start || start_of_file) ? '0 : acc_reg;

    // Decimal accumulate, saturating just above the dimension limit
    assign digit_val = data_byte - CH_ZERO;
    assign acc_sum   = (MUL_W'(base_acc) << 3) + (MUL_W'(base_acc) << 1) +
                       MUL_W'(digit_val[3:0]);
    assign acc_upd   = (acc_sum >= MUL_W'(ACC_SAT)) ? ACC_SAT : acc_sum[ACC_W-1:0];

    always_comb
    begin
        phase_next      = ph;
        in_comment_next = com;
        in_token_next   = tok;
        tok_pos_next    = base_pos;
        stopped_next    = base_stop;
        acc_next        = base_acc;
        width_next      = width_reg;
        height_next     = height_reg;
        push_c          = 1'b0;
        entry.kind      = ENT_PIXEL_BYTE;
        entry.data      = data_byte;
        entry.code      = ERR_MAGIC;

        // Skip comments up to the line feed
        if (header_ph && com && (data_byte == CH_LF))
        begin
            in_comment_next = 1'b0;
        end
        if (header_ph && !com && !tok && hash)
        begin
            in_comment_next = 1'b1;
        end
        if (tok_start)
        begin
            in_token_next = 1'b1;
        end

        // Take one token byte
        if (tok_start || tok_cont)
        begin
            if (ph == PH_MAGIC)
            begin
                if (((base_pos == 3'd0) && (data_byte != CH_P)) ||
                    ((base_pos == 3'd1) && (data_byte != CH_SIX)) ||
                    (base_pos >= 3'd2))
                begin
                    stopped_next = 1'b1;
                end
                if (base_pos < TOK_POS_MAX)
                begin
                    tok_pos_next = base_pos + 3'd1;
                end
            end
            else if (!base_stop)
            begin
                if (digit)
                begin
                    acc_next = acc_upd;
                    if (base_pos < TOK_POS_MAX)
                    begin
                        tok_pos_next = base_pos + 3'd1;
                    end
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end
        end

        // Judge a token at its terminating whitespace
        if (tok_end)
        begin
            in_token_next = 1'b0;
            case (ph)
                PH_MAGIC:
                begin
                    if (base_stop || (base_pos != 3'd2))
                    begin
                        push_c     = 1'b1;
                        entry.kind = ENT_ERROR;
                        entry.code = ERR_MAGIC;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_WIDTH;
                    end
                end
                PH_WIDTH, PH_HEIGHT:
                begin
                    if (base_pos == 3'd0)
                    begin
                        push_c     = 1'b1;
                        entry.kind = ENT_ERROR;
                        entry.code = ERR_NOT_NUMBER;
                        phase_next = PH_IDLE;
                    end
                    else if (base_acc[DIM_BITS])
                    begin
                        push_c     = 1'b1;
                        entry.kind = ENT_ERROR;
                        entry.code = ERR_TOO_LARGE;
                        phase_next = PH_IDLE;
                    end
                    else if (ph == PH_WIDTH)
                    begin
                        width_next = base_acc[DIM_BITS-1:0];
                        phase_next = PH_HEIGHT;
                    end
                    else
                    begin
                        height_next = base_acc[DIM_BITS-1:0];
                        phase_next  = PH_MAXVAL;
                    end
                end
                default:
                begin
                    push_c = 1'b1;
                    if (base_pos == 3'd0)
                    begin
                        entry.kind = ENT_ERROR;
                        entry.code = ERR_NOT_NUMBER;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        entry.kind = ENT_HEADER;
                        phase_next = ((width_reg == '0) || (height_reg == '0)) ?
                                     PH_IDLE : PH_PIXELS;
                    end
                end
            endcase
        end

        // Forward every byte of the pixel section
        if (ph == PH_PIXELS)
        begin
            push_c     = 1'b1;
            entry.kind = ENT_PIXEL_BYTE;
        end
    end

    assign push       = accept && push_c;
    assign ent_width  = width_reg;
    assign ent_height = height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC;
            in_comment_reg <= 1'b0;
            in_token_reg   <= 1'b0;
            tok_pos_reg    <= '0;
            stopped_reg    <= 1'b0;
            acc_reg        <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            in_comment_reg <= in_comment_next;
            in_token_reg   <= in_token_next;
            tok_pos_reg    <= tok_pos_next;
            stopped_reg    <= stopped_next;
            acc_reg        <= acc_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
        end
    end

endmodule

/* design/ppm_back.sv */
// ---------------------------------------------------------------------------
// ppm_back: pixel assembler and result register
// Groups pixel bytes into RGB, counts columns and rows to mark the last
// pixel, and holds each result until the output takes it.
// ---------------------------------------------------------------------------
module ppm_back import ppm_pkg::*; #(
    parameter int DIM_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  entry_t              entry,
    input  logic [DIM_BITS-1:0] ent_width,
    input  logic [DIM_BITS-1:0] ent_height,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             result
);

    localparam int EXT_W = (DIM_BITS > OUT_DIM_W) ? DIM_BITS : OUT_DIM_W;

    logic                active_reg, active_next;
    logic [1:0]          chan_reg, chan_next;
    logic [7:0]          red_reg, red_next;
    logic [7:0]          green_reg, green_next;
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                can_take;
    logic                produce;
    logic                empty_img;
    logic                last_col;
    logic                last_row;
    logic [EXT_W-1:0]    width_ext;
    logic [EXT_W-1:0]    height_ext;

    // Pop whenever the result register is free or draining
    assign can_take   = !out_valid_reg || res_ready;
    assign q_pop      = q_valid && can_take;
    assign empty_img  = (ent_width == '0) || (ent_height == '0);
    assign last_col   = (col_reg == width_reg - 1'b1);
    assign last_row   = (row_reg == height_reg - 1'b1);
    assign width_ext  = EXT_W'(ent_width);
    assign height_ext = EXT_W'(ent_height);

    always_comb
    begin
        active_next = active_reg;
        chan_next   = chan_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        width_next  = width_reg;
        height_next = height_reg;
        produce     = 1'b0;
        out_next    = '0;

        if (q_pop)
        begin
            case (entry.kind)
                ENT_HEADER:
                begin
                    produce               = 1'b1;
                    out_next.kind         = KIND_HEADER;
                    out_next.image_width  = width_ext[OUT_DIM_W-1:0];
                    out_next.image_height = height_ext[OUT_DIM_W-1:0];
                    out_next.last_pixel   = empty_img;
                    active_next           = !empty_img;
                    width_next            = ent_width;
                    height_next           = ent_height;
                    chan_next             = 2'd0;
                    col_next              = '0;
                    row_next              = '0;
                end
                ENT_ERROR:
                begin
                    produce             = 1'b1;
                    out_next.kind       = KIND_ERROR;
                    out_next.error_code = entry.code;
                    active_next         = 1'b0;
                end
                default:
                begin
                    // Drop pixel bytes once the image is complete
                    if (active_reg)
                    begin
                        case (chan_reg)
                            2'd0:
                            begin
                                red_next  = entry.data;
                                chan_next = 2'd1;
                            end
                            2'd1:
                            begin
                                green_next = entry.data;
                                chan_next  = 2'd2;
                            end
                            default:
                            begin
                                produce             = 1'b1;
                                out_next.kind       = KIND_PIXEL;
                                out_next.red        = red_reg;
                                out_next.green      = green_reg;
                                out_next.blue       = entry.data;
                                out_next.last_pixel = last_col && last_row;
                                chan_next           = 2'd0;
                                if (last_col)
                                begin
                                    col_next = '0;
                                    row_next = row_reg + 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                                if (last_col && last_row)
                                begin
                                    active_next = 1'b0;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end

        // Hold the result until taken
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign result    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            chan_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            chan_reg      <= chan_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg    <= red_next;
        green_reg  <= green_next;
        width_reg  <= width_next;
        height_reg <= height_next;
        if (produce)
        begin
            out_reg <= out_next;
        end
    end

endmodule
